// ===== sv/nzr_pkg.sv =====
package nzr_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 28;
  localparam int ITER_W = 8;
  localparam int TOL_W  = 29;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 29;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd1;

  localparam logic [ITER_W-1:0] MAX_ITER_RST  = 8'd155;
  localparam logic [TOL_W-1:0]  TOLERANCE_RST = 29'd2684;

  // root constants, raw fixed point
  localparam logic signed [WORD_W-1:0] ONE_FX  = 32'sd268435456;
  localparam logic signed [WORD_W-1:0] HALF_FX = 32'sd134217728;
  localparam logic signed [WORD_W-1:0] HS3_FX  = 32'sd232471924;
  localparam logic signed [WORD_W-1:0] VMAX    = 32'sh7fffffff;
  localparam logic signed [WORD_W-1:0] VMIN    = 32'sh80000000;

  localparam logic [2:0] ROOT_ORIGIN = 3'd6;
  localparam logic [2:0] ROOT_NONE   = 3'd7;

  typedef struct packed {
    logic signed [WORD_W-1:0] start_real;
    logic signed [WORD_W-1:0] start_imag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        root_found;
    logic [ITER_W-1:0] step_count;
  } out_item_t;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE, S_TEST, S_TESTW, S_M2A, S_M2B, S_M2C, S_M4A, S_M4B, S_M4C,
    S_M5A, S_M5B, S_M5C, S_SQ, S_SQW, S_DIVR, S_DIVRW, S_DIVI, S_DIVIW,
    S_UPD, S_DONE
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_TEST, OP_M2A, OP_M2B, OP_M2C, OP_M4A, OP_M4B, OP_M4C,
    OP_M5A, OP_M5B, OP_M5C, OP_SQ, OP_SQW, OP_UPD
  } op_t;

  typedef struct packed {
    op_t  op;
    logic div_start;
    logic div_imag;
    logic div_capture;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] hit_root;
    logic       div_done;
  } sts_t;

  function automatic logic signed [WORD_W-1:0] sat_w(input logic signed [WORD_W+1:0] v);
    if (v > $signed({{2{VMAX[WORD_W-1]}}, VMAX})) return VMAX;
    if (v < $signed({{2{VMIN[WORD_W-1]}}, VMIN})) return VMIN;
    return v[WORD_W-1:0];
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_add(input logic signed [WORD_W-1:0] a,
                                                        input logic signed [WORD_W-1:0] b);
    return sat_w({{2{a[WORD_W-1]}}, a} + {{2{b[WORD_W-1]}}, b});
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_sub(input logic signed [WORD_W-1:0] a,
                                                        input logic signed [WORD_W-1:0] b);
    return sat_w({{2{a[WORD_W-1]}}, a} - {{2{b[WORD_W-1]}}, b});
  endfunction

  // exact product, magnitude truncated by FRAC_W, saturated
  function automatic logic signed [WORD_W-1:0] fx_mul(input logic signed [WORD_W-1:0] a,
                                                       input logic signed [WORD_W-1:0] b);
    logic [WORD_W-1:0]     ma;
    logic [WORD_W-1:0]     mb;
    logic [2*WORD_W-1:0]   p;
    logic [2*WORD_W-1:0]   q;
    logic                  neg;
    ma  = a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
    mb  = b[WORD_W-1] ? WORD_W'(-b) : WORD_W'(b);
    neg = a[WORD_W-1] ^ b[WORD_W-1];
    p   = ma * mb;
    q   = p >> FRAC_W;
    if (neg) begin
      if (q > (2*WORD_W)'({1'b1, {(WORD_W-1){1'b0}}})) return VMIN;
      return WORD_W'(-q);
    end
    if (q > (2*WORD_W)'(VMAX)) return VMAX;
    return q[WORD_W-1:0];
  endfunction

  // signed division by six, truncated toward zero, via reciprocal
  function automatic logic signed [WORD_W-1:0] div6(input logic signed [WORD_W-1:0] a);
    logic [WORD_W-1:0]   m;
    logic [2*WORD_W+2:0] p;
    logic [WORD_W-1:0]   q;
    m = a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
    p = m * 35'h2aaaaaaab;
    q = WORD_W'(p >> 36);
    return a[WORD_W-1] ? WORD_W'(-q) : q;
  endfunction

endpackage

// ===== sv/nzr_div.sv =====
module nzr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [nzr_pkg::WORD_W-1:0] num,
  input  logic signed [nzr_pkg::WORD_W-1:0] den,
  output logic                          done,
  output logic signed [nzr_pkg::WORD_W-1:0] quot
);
  import nzr_pkg::*;

  localparam int NB = WORD_W + FRAC_W;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0]     n_r, n_nxt;
  logic [WORD_W:0]   rem_r, rem_nxt;
  logic [NB-1:0]     q_r, q_nxt;
  logic [WORD_W-1:0] d_r, d_nxt;
  logic              neg_r, neg_nxt, zero_r, zero_nxt, pos_r, pos_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [WORD_W:0]   shr;
  logic [WORD_W-1:0] ma;

  // restoring divider, one quotient bit a cycle
  always_comb begin
    n_nxt = n_r; rem_nxt = rem_r; q_nxt = q_r; d_nxt = d_r;
    neg_nxt = neg_r; zero_nxt = zero_r; pos_nxt = pos_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r;
    ma  = num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num);
    shr = {rem_r[WORD_W-1:0], n_r[NB-1]};
    done = 1'b0;
    if (start) begin
      n_nxt    = {ma, {FRAC_W{1'b0}}};
      rem_nxt  = '0;
      q_nxt    = '0;
      d_nxt    = den[WORD_W-1] ? WORD_W'(-den) : WORD_W'(den);
      neg_nxt  = num[WORD_W-1] ^ den[WORD_W-1];
      zero_nxt = (den == '0);
      pos_nxt  = (num > 0);
      cnt_nxt  = CW'(NB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end else begin
        n_nxt   = n_r << 1;
        if (shr >= {1'b0, d_r}) begin
          rem_nxt = shr - {1'b0, d_r};
          q_nxt   = {q_r[NB-2:0], 1'b1};
        end else begin
          rem_nxt = shr;
          q_nxt   = {q_r[NB-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  // sign, saturation and divide-by-zero handling of the quotient
  always_comb begin
    if (zero_r) begin
      quot = pos_r ? VMAX : (neg_r ^ 1'b0 ? VMIN : '0);
      if (!pos_r && n_r == '0 && q_r == '0) quot = '0;
    end else if (neg_r) begin
      quot = (q_r > NB'({1'b1, {(WORD_W-1){1'b0}}})) ? VMIN : WORD_W'(-q_r);
    end else begin
      quot = (q_r > NB'(VMAX)) ? VMAX : q_r[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r <= n_nxt; rem_r <= rem_nxt; q_r <= q_nxt; d_r <= d_nxt;
    neg_r <= neg_nxt; zero_r <= zero_nxt; pos_r <= pos_nxt;
  end
endmodule

// ===== sv/nzr_datapath.sv =====
module nzr_datapath (
  input  logic                        clk,
  input  nzr_pkg::cmd_t               cmd,
  input  nzr_pkg::in_item_t           in_item,
  input  logic [nzr_pkg::TOL_W-1:0]   tolerance,
  output nzr_pkg::sts_t               sts
);
  import nzr_pkg::*;

  logic signed [WORD_W-1:0] cr_r, ci_r, ar_r, ai_r, br_r, bi_r;
  logic signed [WORD_W-1:0] p0_r, p1_r, sq_r, wr_r, wi_r;
  logic signed [WORD_W-1:0] m0, m1, dnum, quot;
  logic                     hit_r;
  logic [2:0]               hroot_r;
  logic signed [WORD_W-1:0] rre [7];
  logic signed [WORD_W-1:0] rim [7];
  logic [6:0]               nears;
  logic                     any_hit;
  logic [2:0]               first;
  logic                     dv_done;

  assign rre = '{ONE_FX, -HALF_FX, -HALF_FX, -ONE_FX, HALF_FX, HALF_FX, '0};
  assign rim = '{'0, HS3_FX, -HS3_FX, '0, HS3_FX, -HS3_FX, '0};

  // distance tests against the six roots and the origin
  for (genvar k = 0; k < 7; k++) begin : g_near
    logic [WORD_W:0]     dx, dy;
    logic [2*WORD_W+2:0] ss;
    always_comb begin
      dx = (cr_r >= rre[k]) ? ({cr_r[WORD_W-1], cr_r} - {rre[k][WORD_W-1], rre[k]})
                            : ({rre[k][WORD_W-1], rre[k]} - {cr_r[WORD_W-1], cr_r});
      dy = (ci_r >= rim[k]) ? ({ci_r[WORD_W-1], ci_r} - {rim[k][WORD_W-1], rim[k]})
                            : ({rim[k][WORD_W-1], rim[k]} - {ci_r[WORD_W-1], ci_r});
      ss = dx[TOL_W-1:0] * dx[TOL_W-1:0] + dy[TOL_W-1:0] * dy[TOL_W-1:0];
      nears[k] = (dx <= (WORD_W+1)'(tolerance)) && (dy <= (WORD_W+1)'(tolerance)) &&
                 (ss <= (2*WORD_W+3)'(tolerance) * (2*WORD_W+3)'(tolerance));
    end
  end

  always_comb begin
    any_hit = |nears;
    first   = ROOT_ORIGIN;
    for (int k = 5; k >= 0; k--) if (nears[k]) first = 3'(k);
  end

  // shared multiplier pair
  always_comb begin
    case (cmd.op)
      OP_M2A:  begin m0 = fx_mul(cr_r, cr_r); m1 = fx_mul(ci_r, ci_r); end
      OP_M2B:  begin m0 = fx_mul(cr_r, ci_r); m1 = fx_mul(ci_r, cr_r); end
      OP_M4A:  begin m0 = fx_mul(ar_r, ar_r); m1 = fx_mul(ai_r, ai_r); end
      OP_M4B:  begin m0 = fx_mul(ar_r, ai_r); m1 = fx_mul(ai_r, ar_r); end
      OP_M5A:  begin m0 = fx_mul(br_r, cr_r); m1 = fx_mul(bi_r, ci_r); end
      OP_M5B:  begin m0 = fx_mul(br_r, ci_r); m1 = fx_mul(bi_r, cr_r); end
      OP_SQ:   begin m0 = fx_mul(ar_r, ar_r); m1 = fx_mul(ai_r, ai_r); end
      default: begin m0 = '0; m1 = '0; end
    endcase
  end

  assign dnum = cmd.div_imag ? ai_r : ar_r;

  nzr_div u_div (
    .clk(clk), .rst_n(1'b1), .start(cmd.div_start), .num(dnum), .den(sq_r),
    .done(dv_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin cr_r <= in_item.start_real; ci_r <= in_item.start_imag; end
      OP_TEST: begin hit_r <= any_hit; hroot_r <= first; end
      OP_M2A, OP_M4A, OP_M5A: begin p0_r <= m0; p1_r <= m1; end
      OP_M2B: begin ar_r <= sat_sub(p0_r, p1_r); ai_r <= sat_add(m0, m1); end
      OP_M4B: begin br_r <= sat_sub(p0_r, p1_r); bi_r <= sat_add(m0, m1); end
      OP_M5B: begin ar_r <= sat_sub(p0_r, p1_r); ai_r <= sat_add(m0, m1); end
      OP_SQ:  begin p0_r <= m0; p1_r <= m1; end
      OP_SQW: sq_r <= sat_add(p0_r, p1_r);
      OP_UPD: begin
        cr_r <= sat_add(cr_r - div6(cr_r), div6(wr_r));
        ci_r <= sat_add(ci_r - div6(ci_r), div6(wi_r));
      end
      default: ;
    endcase
    if (cmd.div_capture) begin
      if (cmd.div_imag) wi_r <= sat_sub('0, quot);
      else              wr_r <= quot;
    end
  end

  assign sts.hit      = hit_r;
  assign sts.hit_root = hroot_r;
  assign sts.div_done = dv_done;
endmodule

// ===== sv/nzr_ctrl.sv =====
module nzr_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  output logic                         out_valid,
  input  logic                         out_stall,
  output nzr_pkg::out_item_t           out_item,
  input  logic [nzr_pkg::ITER_W-1:0]   max_iter,
  input  nzr_pkg::sts_t                sts,
  output nzr_pkg::cmd_t                cmd
);
  import nzr_pkg::*;

  state_t            state_r, state_nxt;
  logic [ITER_W-1:0] n_r, n_nxt;
  out_item_t         res_r, res_nxt;
  logic              ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r; n_nxt = n_r; res_nxt = res_r; ov_nxt = ov_r;
    cmd = '{op: OP_NONE, div_start: 1'b0, div_imag: 1'b0, div_capture: 1'b0};
    in_stall = 1'b1;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = OP_LOAD; n_nxt = '0; state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (n_r == max_iter) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op = OP_TEST; state_nxt = S_TESTW;
        end
      end
      S_TESTW: begin
        if (sts.hit) state_nxt = S_DONE;
        else state_nxt = S_M2A;
      end
      S_M2A: begin cmd.op = OP_M2A; state_nxt = S_M2B; end
      S_M2B: begin cmd.op = OP_M2B; state_nxt = S_M4A; end
      S_M4A: begin cmd.op = OP_M4A; state_nxt = S_M4B; end
      S_M4B: begin cmd.op = OP_M4B; state_nxt = S_M5A; end
      S_M5A: begin cmd.op = OP_M5A; state_nxt = S_M5B; end
      S_M5B: begin cmd.op = OP_M5B; state_nxt = S_SQ; end
      S_SQ:  begin cmd.op = OP_SQ;  state_nxt = S_SQW; end
      S_SQW: begin cmd.op = OP_SQW; state_nxt = S_DIVR; end
      S_DIVR: begin cmd.div_start = 1'b1; state_nxt = S_DIVRW; end
      S_DIVRW: if (sts.div_done) begin
        cmd.div_capture = 1'b1; state_nxt = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_start = 1'b1; cmd.div_imag = 1'b1; state_nxt = S_DIVIW;
      end
      S_DIVIW: begin
        cmd.div_imag = 1'b1;
        if (sts.div_done) begin cmd.div_capture = 1'b1; state_nxt = S_UPD; end
      end
      S_UPD: begin
        cmd.op = OP_UPD; n_nxt = n_r + 1'b1; state_nxt = S_TEST;
      end
      // load the result register only once the previous result has left;
      // a hit always happens below the step limit
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          if (n_r == max_iter) res_nxt = '{root_found: ROOT_NONE, step_count: n_r};
          else res_nxt = '{root_found: sts.hit_root, step_count: n_r};
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    n_r   <= n_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = ov_r;
  assign out_item  = res_r;
endmodule

// ===== sv/newton_z6_root_classifier.sv =====
// Newton root classifier for z^6 - 1, Q4.28 fixed point.
// Each step tests the point against the roots, runs the multiply and square
// states, then uses the bit-serial divider twice per step, then updates.
// One point is handled at a time, for up to max_iterations steps.
// Synchronous active-low reset: registers return to 155 / 2684, no result pending.
module newton_z6_root_classifier (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  nzr_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output nzr_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [nzr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nzr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import nzr_pkg::*;

  logic [ITER_W-1:0] max_iter_r;
  logic [TOL_W-1:0]  tol_r;
  cmd_t              cmd;
  sts_t              sts;
  out_item_t         res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RST;
      tol_r      <= TOLERANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ITER:  max_iter_r <= cfg_data[ITER_W-1:0];
        REG_TOLERANCE: tol_r      <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  nzr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(res),
    .max_iter(max_iter_r), .sts(sts), .cmd(cmd)
  );

  nzr_datapath u_dp (
    .clk(clk), .cmd(cmd), .in_item(in_data), .tolerance(tol_r), .sts(sts)
  );

  assign out_data = res;
endmodule
